// ----- hdl/bpm_pkg.sv -----
// Shared types and constants for the breakpoint match table.
// No dependencies; imported by bpm_table, bpm_cmp and the top level.
`default_nettype none

package bpm_pkg;

  localparam int MAX_ENTRIES  = 16;
  localparam int ADDR_BITS    = 32;
  localparam int LINE_BITS    = 20;
  localparam int FILE_ID_BITS = 16;

  localparam int IDX_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
  localparam int REQ_BITS   = 3;
  localparam int STAT_BITS  = 3;
  localparam int EIDX_BITS  = 4;
  localparam int ECNT_BITS  = 5;

  // input word layout (req_type travels on tuser)
  localparam int IN_FIELDS_W = FILE_ID_BITS + LINE_BITS + ADDR_BITS + 1 + EIDX_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_LINE_LSB = FILE_ID_BITS;
  localparam int IN_ADDR_LSB = FILE_ID_BITS + LINE_BITS;
  localparam int IN_VAL_BIT  = FILE_ID_BITS + LINE_BITS + ADDR_BITS;
  localparam int IN_IDX_LSB  = IN_VAL_BIT + 1;

  // output word layout
  localparam int OUT_FIELDS_W = STAT_BITS + 1 + ECNT_BITS + FILE_ID_BITS + LINE_BITS + ADDR_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [REQ_BITS-1:0] REQ_TOGGLE = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_SET    = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_CHECK  = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_READ   = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 3'd4;

  localparam logic [STAT_BITS-1:0] ST_DONE    = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_ADDED   = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_REMOVED = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_NOINSTR = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_FULL    = 3'd4;
  localparam logic [STAT_BITS-1:0] ST_BADIDX  = 3'd5;

  typedef struct packed {
    logic [FILE_ID_BITS-1:0] file;
    logic [LINE_BITS-1:0]    line;
    logic [ADDR_BITS-1:0]    addr;
  } entry_t;

  typedef enum logic {
    CMP_SRC  = 1'b0,   // file id and line
    CMP_ADDR = 1'b1    // instruction address
  } cmp_mode_t;

endpackage

`default_nettype wire

// ----- hdl/bpm_table.sv -----
// Breakpoint entry store: one write port, one registered read port.
// Depends on bpm_pkg.
`default_nettype none

module bpm_table (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [bpm_pkg::IDX_BITS-1:0] waddr,
  input  wire bpm_pkg::entry_t              wdata,
  input  wire logic [bpm_pkg::IDX_BITS-1:0] raddr,
  output bpm_pkg::entry_t                   rdata
);
  import bpm_pkg::*;

  entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/bpm_cmp.sv -----
// Shared comparator: matches a stored entry against the request key,
// either on file id and line or on address. Depends on bpm_pkg.
`default_nettype none

module bpm_cmp (
  input  wire bpm_pkg::cmp_mode_t mode,
  input  wire bpm_pkg::entry_t    key,
  input  wire bpm_pkg::entry_t    ent,
  output logic                    match
);
  import bpm_pkg::*;

  always_comb begin
    unique case (mode)
      CMP_SRC:  match = (ent.line == key.line) && (ent.file == key.file);
      CMP_ADDR: match = (ent.addr == key.addr);
      default:  match = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/breakpoint_match_table_unit.sv -----
// Breakpoint match table: sequencer, temporary breakpoint and result register.
// Depends on bpm_pkg, bpm_table and bpm_cmp.
//
// Requests arrive on the s_ stream, one word each; every request gives one
// result word on the m_ stream. s_tready is high only while the sequencer is
// idle, so one request is in flight at a time. The entry store is scanned one
// entry per cycle through a single comparator behind a registered read port.
// Path from accept to result, by request type:
//   set temporary, clear, unused codes: start, then result
//   read entry: start, read wait, then result
//   check: start, then result on a temporary hit, otherwise a table scan
//   toggle: a table scan; a remove stops the scan at the match and then
//     moves each later entry down one place
// A new request is taken only after the sequencer has returned to idle.
// The result sits in an output register; if the receiver stalls, the
// sequencer holds in its result state and the next request waits.
// Reset (rst, synchronous) empties the table and disarms the temporary
// breakpoint; entry contents are not cleared and need not be.
`default_nettype none

module breakpoint_match_table_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // file_id, line_number, address, address_valid, entry_index; zero pad
  input  wire logic [bpm_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  wire logic [bpm_pkg::REQ_BITS-1:0]   s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // status, hit, entry_count, entry_file, entry_line, entry_address; zero pad
  output logic [bpm_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import bpm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_START  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_RDWAIT = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t                  state;
  logic [REQ_BITS-1:0]     req;
  entry_t                  key;
  logic                    key_valid;
  logic [EIDX_BITS-1:0]    key_idx;
  logic [CNT_BITS-1:0]     count;
  logic [ADDR_BITS-1:0]    temp_address;
  logic                    temp_armed;
  logic [CNT_BITS-1:0]     scan_idx;
  logic                    pend_valid;
  logic [IDX_BITS-1:0]     pend_idx;
  logic [STAT_BITS-1:0]    res_status;
  logic                    res_hit;
  entry_t                  res_ent;

  logic                    tbl_we;
  logic [IDX_BITS-1:0]     tbl_waddr;
  entry_t                  tbl_wdata;
  logic [IDX_BITS-1:0]     tbl_raddr;
  entry_t                  tbl_rdata;
  cmp_mode_t               cmp_mode;
  logic                    cmp_match;
  logic                    match;
  logic                    scan_more;
  logic                    tbl_full;

  assign s_tready  = (state == S_IDLE);
  assign cmp_mode  = (req == REQ_TOGGLE) ? CMP_SRC : CMP_ADDR;
  assign match     = pend_valid && cmp_match;
  assign scan_more = (scan_idx < count);
  assign tbl_full  = (count >= CNT_BITS'(MAX_ENTRIES));

  bpm_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  bpm_cmp u_cmp (
    .mode  (cmp_mode),
    .key   (key),
    .ent   (tbl_rdata),
    .match (cmp_match)
  );

  always_comb begin
    tbl_raddr = scan_idx[IDX_BITS-1:0];
    if (state == S_START) begin
      tbl_raddr = IDX_BITS'(key_idx);
    end
  end

  // append at the end after a miss, or move an entry down one place
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = count[IDX_BITS-1:0];
    tbl_wdata = key;
    if (state == S_SCAN && req == REQ_TOGGLE && !match && !scan_more && !pend_valid &&
        key_valid && !tbl_full) begin
      tbl_we = 1'b1;
    end else if (state == S_SHIFT && pend_valid) begin
      tbl_we    = 1'b1;
      tbl_waddr = pend_idx - IDX_BITS'(1);
      tbl_wdata = tbl_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      temp_address <= '0;
      temp_armed   <= 1'b0;
      pend_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // the result state loads the output register itself
      if (m_tready && state != S_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req       <= s_tuser;
            key.file  <= s_tdata[FILE_ID_BITS-1:0];
            key.line  <= s_tdata[IN_LINE_LSB +: LINE_BITS];
            key.addr  <= s_tdata[IN_ADDR_LSB +: ADDR_BITS];
            key_valid <= s_tdata[IN_VAL_BIT];
            key_idx   <= s_tdata[IN_IDX_LSB +: EIDX_BITS];
            state     <= S_START;
          end
        end
        S_START: begin
          res_status <= ST_DONE;
          res_hit    <= 1'b0;
          res_ent    <= '0;
          scan_idx   <= '0;
          pend_valid <= 1'b0;
          state      <= S_RESP;
          case (req)
            REQ_TOGGLE: state <= S_SCAN;
            REQ_SET: begin
              temp_address <= key.addr;
              temp_armed   <= 1'b1;
            end
            REQ_CHECK: begin
              if (temp_armed && temp_address == key.addr) begin
                temp_armed <= 1'b0;
                res_hit    <= 1'b1;
              end else begin
                state <= S_SCAN;
              end
            end
            REQ_READ: begin
              if (32'(key_idx) < 32'(count)) begin
                state <= S_RDWAIT;
              end else begin
                res_status <= ST_BADIDX;
              end
            end
            REQ_CLEAR: count <= '0;
            default: ;
          endcase
        end
        S_SCAN: begin
          if (match) begin
            pend_valid <= 1'b0;
            if (req == REQ_TOGGLE) begin
              res_status <= ST_REMOVED;
              scan_idx   <= CNT_BITS'(pend_idx) + CNT_BITS'(1);
              state      <= S_SHIFT;
            end else begin
              res_hit <= 1'b1;
              state   <= S_RESP;
            end
          end else if (scan_more) begin
            pend_valid <= 1'b1;
            pend_idx   <= scan_idx[IDX_BITS-1:0];
            scan_idx   <= scan_idx + CNT_BITS'(1);
          end else if (pend_valid) begin
            pend_valid <= 1'b0;  // last compare missed
          end else begin
            state <= S_RESP;
            if (req == REQ_TOGGLE) begin
              if (!key_valid) begin
                res_status <= ST_NOINSTR;
              end else if (tbl_full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_ADDED;
                count      <= count + CNT_BITS'(1);
              end
            end
          end
        end
        S_SHIFT: begin
          if (scan_more) begin
            pend_valid <= 1'b1;
            pend_idx   <= scan_idx[IDX_BITS-1:0];
            scan_idx   <= scan_idx + CNT_BITS'(1);
          end else begin
            pend_valid <= 1'b0;
            if (!pend_valid) begin
              count <= count - CNT_BITS'(1);
              state <= S_RESP;
            end
          end
        end
        S_RDWAIT: begin
          res_ent <= tbl_rdata;
          state   <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'({res_ent.addr, res_ent.line, res_ent.file,
                                     ECNT_BITS'(count), res_hit, res_status});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (state == S_SCAN || state == S_SHIFT))
    else $error("table written outside scan or shift");

  a_temp_disarm: assert property (@(posedge clk) disable iff (rst)
    $fell(temp_armed) |-> ($past(state) == S_START && $past(req) == REQ_CHECK))
    else $error("temporary breakpoint disarmed without a check");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_SHIFT) |-> scan_idx <= count)
    else $error("scan index past entry count");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && !scan_more && !pend_valid) |=> count == $past(count) - CNT_BITS'(1))
    else $error("removal did not shrink the table");
`endif

endmodule

`default_nettype wire
